[sv/sam_pkg.sv]
// shared types, constants and threshold step functions of the sensor alarm monitor
package sam_pkg;

  // action codes of an input word
  localparam logic [1:0] ACT_MONITOR = 2'd0;
  localparam logic [1:0] ACT_MODE    = 2'd1;
  localparam logic [1:0] ACT_UP      = 2'd2;
  localparam logic [1:0] ACT_DOWN    = 2'd3;

  // alert codes of a result word
  localparam logic [2:0] ALERT_NONE  = 3'd0;
  localparam logic [2:0] ALERT_TEMP  = 3'd1;
  localparam logic [2:0] ALERT_HUMID = 3'd2;
  localparam logic [2:0] ALERT_GAS   = 3'd3;
  localparam logic [2:0] ALERT_VIB   = 3'd4;

  // menu steps
  localparam logic [1:0] STEP_TEMP  = 2'd0;
  localparam logic [1:0] STEP_HUMID = 2'd1;
  localparam logic [1:0] STEP_GAS   = 2'd2;
  localparam logic [1:0] STEP_BACK  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_KEY_GUARD   = 3'd0;
  localparam logic [2:0] CFG_CLIMATE_PER = 3'd1;
  localparam logic [2:0] CFG_GAS_PER     = 3'd2;
  localparam logic [2:0] CFG_VIB_HOLD    = 3'd3;
  localparam logic [2:0] CFG_BEEP_HOLD   = 3'd4;
  localparam logic [2:0] CFG_MOTION_PASS = 3'd5;

  // configuration reset values
  localparam logic [15:0] KEY_GUARD_RST   = 16'd200;
  localparam logic [15:0] CLIMATE_PER_RST = 16'd2000;
  localparam logic [15:0] GAS_PER_RST     = 16'd500;
  localparam logic [15:0] VIB_HOLD_RST    = 16'd3000;
  localparam logic [15:0] BEEP_HOLD_RST   = 16'd5000;
  localparam logic [7:0]  MOTION_PASS_RST = 8'd10;

  // threshold ranges and reset values
  localparam logic [5:0] TEMP_LO  = 6'd15;
  localparam logic [5:0] TEMP_HI  = 6'd50;
  localparam logic [5:0] TEMP_RST = 6'd30;
  localparam logic [6:0] HUMID_LO  = 7'd90;
  localparam logic [6:0] HUMID_HI  = 7'd120;
  localparam logic [6:0] HUMID_RST = 7'd100;
  localparam logic [8:0] GAS_LO  = 9'd200;
  localparam logic [8:0] GAS_HI  = 9'd300;
  localparam logic [8:0] GAS_RST = 9'd240;

  localparam logic [7:0] MOTION_MAX = 8'd255;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [7:0]  temperature;
    logic [7:0]  humidity;
    logic [11:0] gas_level;
    logic        motion_high;
    logic        shake_seen;
  } in_word_t;

  typedef struct packed {
    logic [2:0] alert_kind;
    logic       last;
    logic       people_present;
    logic       vibration_on;
    logic       beep_on;
    logic       menu_active;
    logic [1:0] menu_step;
    logic [5:0] temp_limit;
    logic [6:0] humid_limit;
    logic [8:0] gas_limit;
    logic       save_now;
  } out_word_t;

  // status shared by every result of one input word
  typedef struct packed {
    logic       people_present;
    logic       vibration_on;
    logic       beep_on;
    logic       menu_active;
    logic [1:0] menu_step;
    logic [5:0] temp_limit;
    logic [6:0] humid_limit;
    logic [8:0] gas_limit;
    logic       save_now;
  } status_t;

  // all results of one input word
  typedef struct packed {
    logic [3:0][2:0] kinds;
    logic [1:0]      last_idx;
    status_t         status;
  } bundle_t;

  function automatic logic [5:0] temp_step(input logic [5:0] v, input logic up);
    if (up) begin
      temp_step = (v >= TEMP_HI) ? TEMP_LO : v + 6'd1;
    end else begin
      temp_step = (v <= TEMP_LO) ? TEMP_HI : v - 6'd1;
    end
  endfunction

  function automatic logic [6:0] humid_step(input logic [6:0] v, input logic up);
    if (up) begin
      humid_step = (v >= HUMID_HI) ? HUMID_LO : v + 7'd1;
    end else begin
      humid_step = (v <= HUMID_LO) ? HUMID_HI : v - 7'd1;
    end
  endfunction

  function automatic logic [8:0] gas_step(input logic [8:0] v, input logic up);
    if (up) begin
      gas_step = (v >= GAS_HI) ? GAS_LO : v + 9'd1;
    end else begin
      gas_step = (v <= GAS_LO) ? GAS_HI : v - 9'd1;
    end
  endfunction

endpackage

[sv/sam_core.sv]
// input register, configuration, monitor state and single-pass update logic
module sam_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sam_pkg::in_word_t  in_data,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_value,
  output logic               push,
  output sam_pkg::bundle_t   push_bundle,
  input  logic               full
);

  // configuration
  logic [15:0] key_guard, climate_per, gas_per, vib_hold, beep_hold;
  logic [7:0]  motion_pass;

  // input register
  logic              hold_valid;
  sam_pkg::in_word_t hold;

  // monitor state
  logic        menu_flag;
  logic [1:0]  menu_index;
  logic [5:0]  temp_lim;
  logic [6:0]  humid_lim;
  logic [8:0]  gas_lim;
  logic [31:0] key_time, climate_time, gas_time, shake_time, beep_time;
  logic [2:0]  sent_flags;
  logic [7:0]  motion_count;
  logic        people_flag, shake_active, beeper_on;

  logic        menu_flag_next;
  logic [1:0]  menu_index_next;
  logic [5:0]  temp_lim_next;
  logic [6:0]  humid_lim_next;
  logic [8:0]  gas_lim_next;
  logic [31:0] key_time_next, climate_time_next, gas_time_next;
  logic [31:0] shake_time_next, beep_time_next;
  logic [2:0]  sent_flags_next;
  logic [7:0]  motion_count_next;
  logic        people_flag_next, shake_active_next, beeper_on_next;
  logic        save;
  logic [3:0]  raise;

  assign push     = hold_valid && !full;
  assign in_ready = !hold_valid || !full;

  // next state for the word in the input register
  always_comb begin
    logic [31:0] key_dt, clim_dt, gas_dt, shake_dt, beep_dt;
    logic        up;
    key_dt   = hold.now_ms - key_time;
    clim_dt  = hold.now_ms - climate_time;
    gas_dt   = hold.now_ms - gas_time;
    up       = (hold.action == sam_pkg::ACT_UP);

    menu_flag_next    = menu_flag;
    menu_index_next   = menu_index;
    temp_lim_next     = temp_lim;
    humid_lim_next    = humid_lim;
    gas_lim_next      = gas_lim;
    key_time_next     = key_time;
    climate_time_next = climate_time;
    gas_time_next     = gas_time;
    shake_time_next   = shake_time;
    beep_time_next    = beep_time;
    sent_flags_next   = sent_flags;
    motion_count_next = motion_count;
    people_flag_next  = people_flag;
    shake_active_next = shake_active;
    beeper_on_next    = beeper_on;
    save              = 1'b0;
    raise             = 4'b0000;
    shake_dt          = '0;
    beep_dt           = '0;

    if (hold.action != sam_pkg::ACT_MONITOR) begin
      // debounced key handling
      if (key_dt >= {16'd0, key_guard}) begin
        key_time_next = hold.now_ms;
        if (hold.action == sam_pkg::ACT_MODE) begin
          if (!menu_flag) begin
            menu_flag_next  = 1'b1;
            menu_index_next = sam_pkg::STEP_TEMP;
          end else if (menu_index == sam_pkg::STEP_BACK) begin
            menu_flag_next  = 1'b0;
            menu_index_next = sam_pkg::STEP_TEMP;
            save            = 1'b1;
          end else begin
            menu_index_next = menu_index + 2'd1;
          end
        end else if (menu_flag) begin
          case (menu_index)
            sam_pkg::STEP_TEMP:  temp_lim_next  = sam_pkg::temp_step(temp_lim, up);
            sam_pkg::STEP_HUMID: humid_lim_next = sam_pkg::humid_step(humid_lim, up);
            sam_pkg::STEP_GAS:   gas_lim_next   = sam_pkg::gas_step(gas_lim, up);
            default: ;
          endcase
        end
      end
    end else if (!menu_flag) begin
      // climate gate
      if (clim_dt >= {16'd0, climate_per}) begin
        climate_time_next = hold.now_ms;
        if (hold.temperature > {2'd0, temp_lim}) begin
          raise[0]           = !sent_flags[0];
          sent_flags_next[0] = 1'b1;
        end else begin
          sent_flags_next[0] = 1'b0;
        end
        if (hold.humidity > {1'b0, humid_lim}) begin
          raise[1]           = !sent_flags[1];
          sent_flags_next[1] = 1'b1;
        end else begin
          sent_flags_next[1] = 1'b0;
        end
      end
      // gas gate
      if (gas_dt >= {16'd0, gas_per}) begin
        gas_time_next = hold.now_ms;
        if (hold.gas_level > {3'd0, gas_lim}) begin
          raise[2]           = !sent_flags[2];
          sent_flags_next[2] = 1'b1;
        end else begin
          sent_flags_next[2] = 1'b0;
        end
      end
      // motion qualification, saturating
      if (hold.motion_high) begin
        if (motion_count != sam_pkg::MOTION_MAX) begin
          motion_count_next = motion_count + 8'd1;
        end
        if (motion_count_next >= motion_pass) begin
          people_flag_next = 1'b1;
        end
      end else begin
        motion_count_next = '0;
        people_flag_next  = 1'b0;
      end
      // vibration hold
      if (hold.shake_seen && !shake_active) begin
        shake_active_next = 1'b1;
        shake_time_next   = hold.now_ms;
        raise[3]          = 1'b1;
      end
      shake_dt = hold.now_ms - shake_time_next;
      if (shake_active_next && shake_dt >= {16'd0, vib_hold}) begin
        shake_active_next = 1'b0;
      end
      // beeper timer
      if (people_flag_next && !beeper_on) begin
        beeper_on_next = 1'b1;
        beep_time_next = hold.now_ms;
      end
      beep_dt = hold.now_ms - beep_time_next;
      if (beeper_on_next && beep_dt >= {16'd0, beep_hold}) begin
        beeper_on_next = 1'b0;
      end
    end
  end

  // pack raised alerts in fixed order into the result bundle
  always_comb begin
    logic [2:0] pos;
    pos = '0;
    push_bundle.kinds = {4{sam_pkg::ALERT_NONE}};
    for (int i = 0; i < 4; i++) begin
      if (raise[i]) begin
        push_bundle.kinds[pos[1:0]] = sam_pkg::ALERT_TEMP + 3'(i);
        pos = pos + 3'd1;
      end
    end
    push_bundle.last_idx              = (pos == 3'd0) ? 2'd0 : 2'(pos - 3'd1);
    push_bundle.status.people_present = people_flag_next;
    push_bundle.status.vibration_on   = shake_active_next;
    push_bundle.status.beep_on        = beeper_on_next;
    push_bundle.status.menu_active    = menu_flag_next;
    push_bundle.status.menu_step      = menu_index_next;
    push_bundle.status.temp_limit     = temp_lim_next;
    push_bundle.status.humid_limit    = humid_lim_next;
    push_bundle.status.gas_limit      = gas_lim_next;
    push_bundle.status.save_now       = save;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      hold <= in_data;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_guard   <= sam_pkg::KEY_GUARD_RST;
      climate_per <= sam_pkg::CLIMATE_PER_RST;
      gas_per     <= sam_pkg::GAS_PER_RST;
      vib_hold    <= sam_pkg::VIB_HOLD_RST;
      beep_hold   <= sam_pkg::BEEP_HOLD_RST;
      motion_pass <= sam_pkg::MOTION_PASS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sam_pkg::CFG_KEY_GUARD:   key_guard   <= cfg_value;
        sam_pkg::CFG_CLIMATE_PER: climate_per <= cfg_value;
        sam_pkg::CFG_GAS_PER:     gas_per     <= cfg_value;
        sam_pkg::CFG_VIB_HOLD:    vib_hold    <= cfg_value;
        sam_pkg::CFG_BEEP_HOLD:   beep_hold   <= cfg_value;
        sam_pkg::CFG_MOTION_PASS: motion_pass <= cfg_value[7:0];
        default: ;
      endcase
    end
  end

  // monitor state
  always_ff @(posedge clk) begin
    if (rst) begin
      menu_flag    <= 1'b0;
      menu_index   <= sam_pkg::STEP_TEMP;
      temp_lim     <= sam_pkg::TEMP_RST;
      humid_lim    <= sam_pkg::HUMID_RST;
      gas_lim      <= sam_pkg::GAS_RST;
      key_time     <= '0;
      climate_time <= '0;
      gas_time     <= '0;
      shake_time   <= '0;
      beep_time    <= '0;
      sent_flags   <= '0;
      motion_count <= '0;
      people_flag  <= 1'b0;
      shake_active <= 1'b0;
      beeper_on    <= 1'b0;
    end else if (push) begin
      menu_flag    <= menu_flag_next;
      menu_index   <= menu_index_next;
      temp_lim     <= temp_lim_next;
      humid_lim    <= humid_lim_next;
      gas_lim      <= gas_lim_next;
      key_time     <= key_time_next;
      climate_time <= climate_time_next;
      gas_time     <= gas_time_next;
      shake_time   <= shake_time_next;
      beep_time    <= beep_time_next;
      sent_flags   <= sent_flags_next;
      motion_count <= motion_count_next;
      people_flag  <= people_flag_next;
      shake_active <= shake_active_next;
      beeper_on    <= beeper_on_next;
    end
  end

endmodule

[sv/sam_queue.sv]
// two-entry result bundle queue that sends one result word per cycle while out_ready is high
module sam_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sam_pkg::bundle_t    push_bundle,
  output logic                full,
  output logic                out_valid,
  input  logic                out_ready,
  output sam_pkg::out_word_t  out_data
);

  sam_pkg::bundle_t slots [2];
  logic       head, tail;
  logic [1:0] count;
  logic [1:0] sub;
  logic       pop, take, is_last;
  sam_pkg::bundle_t cur;

  assign cur       = slots[head];
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign take      = out_valid && out_ready;
  assign is_last   = (sub == cur.last_idx);
  assign pop       = take && is_last;

  // result word from the head bundle
  always_comb begin
    out_data.alert_kind     = cur.kinds[sub];
    out_data.last           = is_last;
    out_data.people_present = cur.status.people_present;
    out_data.vibration_on   = cur.status.vibration_on;
    out_data.beep_on        = cur.status.beep_on;
    out_data.menu_active    = cur.status.menu_active;
    out_data.menu_step      = cur.status.menu_step;
    out_data.temp_limit     = cur.status.temp_limit;
    out_data.humid_limit    = cur.status.humid_limit;
    out_data.gas_limit      = cur.status.gas_limit;
    out_data.save_now       = cur.status.save_now;
  end

  // pointers, fill count and result index
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= '0;
      sub   <= '0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
        sub  <= '0;
      end else if (take) begin
        sub <= sub + 2'd1;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // bundle storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_bundle;
    end
  end

endmodule

[sv/sensor_alarm_monitor_top.sv]
// top level of the sensor alarm monitor
// Accepts one input word per cycle while the two-entry result queue has room. An item
// passes through the input register, is evaluated combinationally and leaves one to four
// result words, sent from the queue one per cycle while out_ready is high; the result
// port is therefore the limit, and a monitor pass raising k alerts occupies the output
// for k result words, read from a queue slot that the evaluated input register fills.
// Configuration writes are always taken and apply to the next evaluated item.
module sensor_alarm_monitor_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sam_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sam_pkg::out_word_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_value
);

  logic             push, full;
  sam_pkg::bundle_t push_bundle;

  assign cfg_ready = 1'b1;

  // evaluation stage
  sam_core u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_value   (cfg_value),
    .push        (push),
    .push_bundle (push_bundle),
    .full        (full)
  );

  // result queue
  sam_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_bundle (push_bundle),
    .full        (full),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

[sv/sam_checker.sv]
// port-level checks of the sensor alarm monitor and their binding
module sam_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input sam_pkg::out_word_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // a save request only comes with the menu left
  a_save_exit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.save_now |->
      !out_data.menu_active && out_data.menu_step == sam_pkg::STEP_TEMP)
    else $error("save request while menu still open");

  // outside the menu the step reads as the first one
  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.menu_active |-> out_data.menu_step == sam_pkg::STEP_TEMP)
    else $error("menu step set outside the menu");

  // thresholds stay inside their ranges
  a_limits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.temp_limit >= sam_pkg::TEMP_LO
      && out_data.temp_limit <= sam_pkg::TEMP_HI
      && out_data.humid_limit >= sam_pkg::HUMID_LO
      && out_data.humid_limit <= sam_pkg::HUMID_HI
      && out_data.gas_limit >= sam_pkg::GAS_LO
      && out_data.gas_limit <= sam_pkg::GAS_HI)
    else $error("threshold out of range");

endmodule

bind sensor_alarm_monitor_top sam_checker u_sam_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/sv/tb_sensor_alarm_monitor_top.sv]
// self-checking testbench of the sensor alarm monitor: key menu, sensor alerts and timers
module tb_sensor_alarm_monitor_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sam_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 8;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned SLIP_SHOWN    = 10;

  // register indexes outside the map, written to check they are ignored
  localparam logic [2:0] CFG_VOID_LO = 3'd6;
  localparam logic [2:0] CFG_VOID_HI = 3'd7;

  // what the sender queue holds: a sensor word, a register write or a drain pause
  typedef enum logic [1:0] {FEED_WORD, FEED_SETTING, FEED_HOLD} feed_kind_t;

  typedef struct packed {
    feed_kind_t  kind;
    in_word_t    word;
    logic [2:0]  idx;
    logic [15:0] val;
    logic        calm;
  } feed_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_word_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_value = '0;

  sensor_alarm_monitor_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_value (cfg_value)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  feed_t       feed [$];
  out_word_t   alarm_words_due [$];
  int unsigned slip_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hush_cycles  = 0;
  logic        calm_now     = 1'b0;

  // predicted configuration
  logic [15:0] guard_cfg   = KEY_GUARD_RST;
  logic [15:0] climate_cfg = CLIMATE_PER_RST;
  logic [15:0] gas_cfg     = GAS_PER_RST;
  logic [15:0] vib_cfg     = VIB_HOLD_RST;
  logic [15:0] beep_cfg    = BEEP_HOLD_RST;
  logic [7:0]  motion_cfg  = MOTION_PASS_RST;

  // predicted state
  logic        menu_on     = 1'b0;
  logic [1:0]  menu_at     = STEP_TEMP;
  logic [5:0]  lim_temp    = TEMP_RST;
  logic [6:0]  lim_humid   = HUMID_RST;
  logic [8:0]  lim_gas     = GAS_RST;
  logic [31:0] key_ms      = '0;
  logic [31:0] climate_ms  = '0;
  logic [31:0] gas_ms      = '0;
  logic [2:0]  alert_sent  = '0;
  logic [7:0]  motion_run  = '0;
  logic        present     = 1'b0;
  logic        shaking     = 1'b0;
  logic [31:0] shake_ms    = '0;
  logic        beeping     = 1'b0;
  logic [31:0] beep_ms     = '0;

  // one threshold step with wrap-around at either end of its range
  function automatic logic [8:0] nudge_limit(input logic [8:0] v, input logic [8:0] lo,
                                             input logic [8:0] hi, input logic up);
    if (up) return (v >= hi) ? lo : v + 9'd1;
    return (v <= lo) ? hi : v - 9'd1;
  endfunction

  task automatic apply_setting(input logic [2:0] idx, input logic [15:0] v);
    case (idx)
      CFG_KEY_GUARD:   guard_cfg   = v;
      CFG_CLIMATE_PER: climate_cfg = v;
      CFG_GAS_PER:     gas_cfg     = v;
      CFG_VIB_HOLD:    vib_cfg     = v;
      CFG_BEEP_HOLD:   beep_cfg    = v;
      CFG_MOTION_PASS: motion_cfg  = v[7:0];
      default: ;
    endcase
  endtask

  // works out the alarm words one accepted sensor word gives and queues them
  task automatic predict_alarm_words(input in_word_t w);
    logic [2:0] kinds [4];
    int         n;
    logic       save;
    out_word_t  o;
    n = 0;
    save = 1'b0;
    if (w.action != ACT_MONITOR) begin
      // debounced key handling
      if (w.now_ms - key_ms >= 32'(guard_cfg)) begin
        key_ms = w.now_ms;
        if (w.action == ACT_MODE) begin
          if (!menu_on) begin
            menu_on = 1'b1;
            menu_at = STEP_TEMP;
          end else if (menu_at == STEP_BACK) begin
            menu_on = 1'b0;
            menu_at = STEP_TEMP;
            save = 1'b1;
          end else begin
            menu_at = menu_at + 2'd1;
          end
        end else if (menu_on) begin
          case (menu_at)
            STEP_TEMP:  lim_temp  = 6'(nudge_limit(9'(lim_temp), 9'(TEMP_LO), 9'(TEMP_HI),
                                                   w.action == ACT_UP));
            STEP_HUMID: lim_humid = 7'(nudge_limit(9'(lim_humid), 9'(HUMID_LO), 9'(HUMID_HI),
                                                   w.action == ACT_UP));
            STEP_GAS:   lim_gas   = nudge_limit(lim_gas, GAS_LO, GAS_HI, w.action == ACT_UP);
            default: ;
          endcase
        end
      end
    end else if (!menu_on) begin
      // climate gate: temperature then humidity
      if (w.now_ms - climate_ms >= 32'(climate_cfg)) begin
        climate_ms = w.now_ms;
        if (w.temperature > 8'(lim_temp)) begin
          if (!alert_sent[0]) begin
            kinds[n] = ALERT_TEMP;
            n++;
            alert_sent[0] = 1'b1;
          end
        end else begin
          alert_sent[0] = 1'b0;
        end
        if (w.humidity > 8'(lim_humid)) begin
          if (!alert_sent[1]) begin
            kinds[n] = ALERT_HUMID;
            n++;
            alert_sent[1] = 1'b1;
          end
        end else begin
          alert_sent[1] = 1'b0;
        end
      end
      // gas gate
      if (w.now_ms - gas_ms >= 32'(gas_cfg)) begin
        gas_ms = w.now_ms;
        if (w.gas_level > 12'(lim_gas)) begin
          if (!alert_sent[2]) begin
            kinds[n] = ALERT_GAS;
            n++;
            alert_sent[2] = 1'b1;
          end
        end else begin
          alert_sent[2] = 1'b0;
        end
      end
      // motion qualification, counter saturates
      if (w.motion_high) begin
        if (motion_run != MOTION_MAX) motion_run = motion_run + 8'd1;
        if (motion_run >= motion_cfg) present = 1'b1;
      end else begin
        motion_run = '0;
        present = 1'b0;
      end
      // vibration hold
      if (w.shake_seen && !shaking) begin
        shaking = 1'b1;
        shake_ms = w.now_ms;
        kinds[n] = ALERT_VIB;
        n++;
      end
      if (shaking && (w.now_ms - shake_ms >= 32'(vib_cfg))) shaking = 1'b0;
      // beeper timer
      if (present && !beeping) begin
        beeping = 1'b1;
        beep_ms = w.now_ms;
      end
      if (beeping && (w.now_ms - beep_ms >= 32'(beep_cfg))) beeping = 1'b0;
    end
    if (n == 0) begin
      kinds[0] = ALERT_NONE;
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      o.alert_kind     = kinds[k];
      o.last           = (k == n - 1);
      o.people_present = present;
      o.vibration_on   = shaking;
      o.beep_on        = beeping;
      o.menu_active    = menu_on;
      o.menu_step      = menu_at;
      o.temp_limit     = lim_temp;
      o.humid_limit    = lim_humid;
      o.gas_limit      = lim_gas;
      o.save_now       = save;
      alarm_words_due.push_back(o);
    end
  endtask

  function automatic string field_slips(input out_word_t got, input out_word_t want);
    string s = "";
    if (got.alert_kind !== want.alert_kind) s = {s, " alert_kind"};
    if (got.last !== want.last) s = {s, " last"};
    if (got.people_present !== want.people_present) s = {s, " people_present"};
    if (got.vibration_on !== want.vibration_on) s = {s, " vibration_on"};
    if (got.beep_on !== want.beep_on) s = {s, " beep_on"};
    if (got.menu_active !== want.menu_active) s = {s, " menu_active"};
    if (got.menu_step !== want.menu_step) s = {s, " menu_step"};
    if (got.temp_limit !== want.temp_limit) s = {s, " temp_limit"};
    if (got.humid_limit !== want.humid_limit) s = {s, " humid_limit"};
    if (got.gas_limit !== want.gas_limit) s = {s, " gas_limit"};
    if (got.save_now !== want.save_now) s = {s, " save_now"};
    return s;
  endfunction

  // sender: sensor words and register writes from the feed queue
  always @(posedge clk) begin
    feed_t       f;
    logic        word_taken;
    logic        reg_taken;
    logic        nx_in_valid;
    logic        nx_cfg_valid;
    in_word_t    nx_in_data;
    logic [2:0]  nx_idx;
    logic [15:0] nx_val;
    word_taken   = in_valid && in_ready && !rst;
    reg_taken    = cfg_valid && cfg_ready && !rst;
    nx_in_valid  = in_valid && !word_taken && !rst;
    nx_cfg_valid = cfg_valid && !reg_taken && !rst;
    nx_in_data   = in_data;
    nx_idx       = cfg_index;
    nx_val       = cfg_value;
    if (word_taken) predict_alarm_words(in_data);
    if (reg_taken) apply_setting(cfg_index, cfg_value);
    if (!rst && !nx_in_valid && !nx_cfg_valid && feed.size() != 0) begin
      f = feed[0];
      case (f.kind)
        FEED_WORD: begin
          if (f.calm || $urandom_range(0, 99) >= 30) begin
            nx_in_valid = 1'b1;
            nx_in_data  = f.word;
            calm_now    = f.calm;
            void'(feed.pop_front());
          end
        end
        FEED_SETTING: begin
          if (quiet_cycles >= SETTLE_CYCLES) begin
            nx_cfg_valid = 1'b1;
            nx_idx       = f.idx;
            nx_val       = f.val;
            void'(feed.pop_front());
          end
        end
        default: begin
          if (alarm_words_due.size() == 0) void'(feed.pop_front());
        end
      endcase
    end
    // idle count that gates register writes
    if (nx_in_valid || nx_cfg_valid || alarm_words_due.size() != 0) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    in_valid  <= nx_in_valid;
    in_data   <= nx_in_data;
    cfg_valid <= nx_cfg_valid;
    cfg_index <= nx_idx;
    cfg_value <= nx_val;
  end

  // receiver: checks each alarm word against the oldest prediction
  always @(posedge clk) begin
    out_word_t want;
    string     slips;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (alarm_words_due.size() == 0) begin
          if (slip_count < SLIP_SHOWN) $display("unexpected alarm word %h", out_data);
          slip_count++;
        end else begin
          want  = alarm_words_due.pop_front();
          slips = field_slips(out_data, want);
          if (slips != "") begin
            if (slip_count < SLIP_SHOWN) begin
              $display("alarm word mismatch in%s: expected %h, got %h", slips, want, out_data);
            end
            slip_count++;
          end
        end
      end
      out_ready <= calm_now || ($urandom_range(0, 99) >= 30);
    end
  end

  // cycles without any word moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      hush_cycles <= 0;
    end else begin
      hush_cycles <= hush_cycles + 1;
    end
  end

  initial begin
    wait (hush_cycles >= STALL_LIMIT);
    $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  // stimulus planning
  int unsigned gen_ms        = 0;
  int unsigned plan_step     = 0;
  int unsigned planned_words = 0;
  logic [15:0] plan_guard    = KEY_GUARD_RST;
  logic        plan_calm     = 1'b0;
  logic        mot_level     = 1'b0;

  task automatic add_word(input logic [1:0] act, input logic [31:0] ms, input logic [7:0] t,
                          input logic [7:0] h, input logic [11:0] g, input logic m,
                          input logic s);
    feed_t f;
    f = '0;
    f.kind              = FEED_WORD;
    f.word.action       = act;
    f.word.now_ms       = ms;
    f.word.temperature  = t;
    f.word.humidity     = h;
    f.word.gas_level    = g;
    f.word.motion_high  = m;
    f.word.shake_seen   = s;
    f.calm              = plan_calm;
    feed.push_back(f);
    planned_words++;
  endtask

  task automatic add_setting(input logic [2:0] idx, input logic [15:0] v);
    feed_t f;
    f = '0;
    f.kind = FEED_SETTING;
    f.idx  = idx;
    f.val  = v;
    feed.push_back(f);
    if (idx == CFG_KEY_GUARD) plan_guard = v;
  endtask

  task automatic add_hold();
    feed_t f;
    f = '0;
    f.kind = FEED_HOLD;
    feed.push_back(f);
  endtask

  task automatic load_timing(input logic [15:0] guard, input logic [15:0] climate,
                             input logic [15:0] gas, input logic [15:0] vib,
                             input logic [15:0] beep, input logic [7:0] passes);
    add_setting(CFG_KEY_GUARD, guard);
    add_setting(CFG_CLIMATE_PER, climate);
    add_setting(CFG_GAS_PER, gas);
    add_setting(CFG_VIB_HOLD, vib);
    add_setting(CFG_BEEP_HOLD, beep);
    add_setting(CFG_MOTION_PASS, {8'd0, passes});
  endtask

  // readings clustered around the threshold ranges, with extremes and noise
  function automatic logic [11:0] near_limit(input int unsigned lo, input int unsigned hi,
                                             input int unsigned top);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 12'($urandom_range(lo - 2, hi + 2));
    if (r == 4) return 12'd0;
    if (r == 5) return 12'(top);
    return 12'($urandom_range(0, top));
  endfunction

  task automatic add_monitor(input logic m);
    if ($urandom_range(0, 99) < 3) gen_ms = $urandom;
    else gen_ms += $urandom_range(0, plan_step);
    add_word(ACT_MONITOR, gen_ms, 8'(near_limit(15, 50, 255)), 8'(near_limit(90, 120, 255)),
             near_limit(200, 300, 4095), m, $urandom_range(0, 99) < 12);
  endtask

  // a key press, sometimes inside the debounce window when allowed
  task automatic add_key(input logic [1:0] act, input logic may_be_early);
    if (may_be_early && plan_guard != 0 && $urandom_range(0, 99) < 15) begin
      gen_ms += $urandom_range(0, plan_guard - 1);
    end else begin
      gen_ms += plan_guard + $urandom_range(0, 20);
    end
    add_word(act, gen_ms, 8'($urandom), 8'($urandom), 12'($urandom), 1'($urandom),
             1'($urandom));
  endtask

  // full menu visit: enter, adjust each step, leave from the back step
  task automatic add_session();
    int unsigned len;
    logic        up;
    add_key(ACT_MODE, 1'b0);
    for (int st = 0; st < 4; st++) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 4);
      up  = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < 6) add_monitor(mot_level);
        add_key(up ? ACT_UP : ACT_DOWN, 1'b1);
      end
      add_key(ACT_MODE, 1'b0);
    end
  endtask

  task automatic random_mix(input int unsigned count);
    int unsigned goal;
    int unsigned r;
    int unsigned run;
    goal = planned_words + count;
    while (planned_words < goal) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        add_session();
      end else if (r < 20) begin
        run = $urandom_range(1, 3);
        repeat (run) add_key($urandom_range(0, 1) ? ACT_UP : ACT_DOWN, 1'b1);
      end else begin
        run = $urandom_range(1, 10);
        repeat (run) begin
          if ($urandom_range(0, 99) < 15) mot_level = ~mot_level;
          add_monitor(mot_level);
        end
      end
    end
  endtask

  initial begin
    // directed words under the reset timing
    add_word(ACT_MONITOR, 32'd0,     8'd255, 8'd255, 12'd4095, 1'b1, 1'b1);
    add_word(ACT_MONITOR, 32'd4000,  8'd255, 8'd255, 12'd4095, 1'b1, 1'b1);
    add_word(ACT_MONITOR, 32'd4001,  8'd255, 8'd255, 12'd4095, 1'b1, 1'b1);
    add_word(ACT_MONITOR, 32'd8000,  8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    add_word(ACT_MONITOR, 32'd12000, 8'd255, 8'd255, 12'd4095, 1'b1, 1'b1);
    // menu walk: early key, pass ignored in menu, one step each way, back step
    add_word(ACT_MODE,    32'd12001, 8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    add_word(ACT_UP,      32'd12100, 8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    add_word(ACT_MONITOR, 32'd12300, 8'd255, 8'd255, 12'd4095, 1'b1, 1'b1);
    add_word(ACT_UP,      32'd12400, 8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    add_word(ACT_DOWN,    32'd12600, 8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    add_word(ACT_MODE,    32'd12800, 8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    add_word(ACT_DOWN,    32'd13000, 8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    add_word(ACT_MODE,    32'd13200, 8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    add_word(ACT_UP,      32'd13400, 8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    add_word(ACT_MODE,    32'd13600, 8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    add_word(ACT_UP,      32'd13800, 8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    add_word(ACT_DOWN,    32'd14000, 8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    add_word(ACT_MODE,    32'd14200, 8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    // keys outside the menu still restart the debounce window
    add_word(ACT_UP,      32'd14300, 8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    add_word(ACT_DOWN,    32'd14500, 8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    add_word(ACT_MODE,    32'd14600, 8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    // timestamp wrap for gates and keys, guard boundary on both sides
    add_word(ACT_MONITOR, 32'hFFFF_FFF0, 8'd20, 8'd95, 12'd100, 1'b0, 1'b0);
    add_word(ACT_MONITOR, 32'h0000_0010, 8'd255, 8'd255, 12'd4095, 1'b0, 1'b1);
    add_word(ACT_UP,      32'hFFFF_FFFF, 8'hFF, 8'hFF, 12'hFFF, 1'b1, 1'b1);
    add_word(ACT_DOWN,    32'h0000_00C7, 8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    add_word(ACT_DOWN,    32'h0000_018E, 8'd0,   8'd0,   12'd0,    1'b0, 1'b0);
    gen_ms = 32'h0000_0400;

    // fast timers, no debounce, presence on the first high pass
    load_timing(16'd0, 16'd1, 16'd1, 16'd5, 16'd8, 8'd1);
    plan_step = 4;
    random_mix(50);
    add_hold();
    random_mix(50);

    // widest timers, zero presence count, writes to unmapped indexes
    load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0);
    add_setting(CFG_VOID_LO, 16'hFFFF);
    add_setting(CFG_VOID_HI, 16'h0000);
    plan_step = 70000;
    random_mix(30);

    // zero periods and holds, both sides without idling
    load_timing(16'd5, 16'd0, 16'd0, 16'd0, 16'd0, 8'd3);
    plan_step = 3;
    plan_calm = 1'b1;
    random_mix(50);
    plan_calm = 1'b0;

    // long high motion run past the counter ceiling
    load_timing(16'd40, 16'd30, 16'd10, 16'd25, 16'd60, MOTION_MAX);
    plan_step = 5;
    repeat (258) add_monitor(1'b1);
    add_monitor(1'b0);
    random_mix(10);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (feed.size() != 0 || in_valid || cfg_valid || alarm_words_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (slip_count == 0 && alarm_words_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/sam_pkg.sv
sv/sam_core.sv
sv/sam_queue.sv
sv/sensor_alarm_monitor_top.sv
sv/sam_checker.sv
tb/sv/tb_sensor_alarm_monitor_top.sv
